### hdl/sit_pkg.sv
// Shared constants for the segment intersection test core.
package sit_pkg;

  localparam int COORD_WIDTH_DEF = 16;

endpackage

### hdl/sit_pts_if.sv
// Valid/ready channel that carries the four points of one segment pair.
interface sit_pts_if
  import sit_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] ax;
  logic signed [COORD_WIDTH-1:0] ay;
  logic signed [COORD_WIDTH-1:0] bx;
  logic signed [COORD_WIDTH-1:0] by_coord;
  logic signed [COORD_WIDTH-1:0] cx;
  logic signed [COORD_WIDTH-1:0] cy;
  logic signed [COORD_WIDTH-1:0] dx;
  logic signed [COORD_WIDTH-1:0] dy;

  modport source (output valid, ax, ay, bx, by_coord, cx, cy, dx, dy, input ready);
  modport sink   (input valid, ax, ay, bx, by_coord, cx, cy, dx, dy, output ready);
endinterface

### hdl/sit_res_if.sv
// Valid/ready channel that carries the one-bit crossing result.
interface sit_res_if;
  logic valid;
  logic ready;
  logic hit;

  modport source (output valid, hit, input ready);
  modport sink   (input valid, hit, output ready);
endinterface

### hdl/segment_intersection_test_core.sv
// Pipelined test of whether segment CD crosses segment AB, exact integer arithmetic.
//
//   channel  dir  payload                                   beat
//   pts      in   ax ay bx by_coord cx cy dx dy (signed)    one segment pair
//   res      out  hit                                       one result
//
// One beat enters per cycle while the pipeline is not held full by a stall on res.
// Each beat passes in order through differences, products, cross signs and output.
// Each stage advances when the stage after it is empty or advancing, so a stall on res
// holds every stage in place and nothing is lost or repeated.
// Reset clears the valid bits only.
module segment_intersection_test_core
  import sit_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic      clk,
  input  logic      rst,
  sit_pts_if.sink   pts,
  sit_res_if.source res
);

  localparam int DW = COORD_WIDTH + 1;
  localparam int PW = 2 * DW;
  localparam int CW = PW + 1;

  logic s1_valid, s2_valid, s3_valid, out_valid;
  logic en1, en2, en3, en4;

  // Stage 1: coordinate differences.
  logic signed [DW-1:0] bax, bay, cax, cay, dax, day;
  logic signed [DW-1:0] dcx, dcy, acx, acy, bcx, bcy;

  // Stage 2: products for the four cross products.
  logic signed [PW-1:0] p_bc0, p_bc1, p_bd0, p_bd1;
  logic signed [PW-1:0] p_fa0, p_fa1, p_fb0, p_fb1;

  // Stage 3: signs of the cross products, and zero flags of fa and fb.
  logic signed [CW-1:0] c1, c2, fa, fb;
  logic                 n1, n2, fa_neg, fa_zero, fb_neg, fb_zero;

  logic hit_q;

  assign en4 = !out_valid || res.ready;
  assign en3 = !s3_valid || en4;
  assign en2 = !s2_valid || en3;
  assign en1 = !s1_valid || en2;

  assign pts.ready = en1;
  assign res.valid = out_valid;
  assign res.hit   = hit_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (en1) s1_valid  <= pts.valid;
      if (en2) s2_valid  <= s1_valid;
      if (en3) s3_valid  <= s2_valid;
      if (en4) out_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      bax <= DW'(pts.bx)       - DW'(pts.ax);
      bay <= DW'(pts.by_coord) - DW'(pts.ay);
      cax <= DW'(pts.cx)       - DW'(pts.ax);
      cay <= DW'(pts.cy)       - DW'(pts.ay);
      dax <= DW'(pts.dx)       - DW'(pts.ax);
      day <= DW'(pts.dy)       - DW'(pts.ay);
      dcx <= DW'(pts.dx)       - DW'(pts.cx);
      dcy <= DW'(pts.dy)       - DW'(pts.cy);
      acx <= DW'(pts.ax)       - DW'(pts.cx);
      acy <= DW'(pts.ay)       - DW'(pts.cy);
      bcx <= DW'(pts.bx)       - DW'(pts.cx);
      bcy <= DW'(pts.by_coord) - DW'(pts.cy);
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      p_bc0 <= PW'(bax) * PW'(cay);
      p_bc1 <= PW'(bay) * PW'(cax);
      p_bd0 <= PW'(bax) * PW'(day);
      p_bd1 <= PW'(bay) * PW'(dax);
      p_fa0 <= PW'(dcx) * PW'(acy);
      p_fa1 <= PW'(dcy) * PW'(acx);
      p_fb0 <= PW'(dcx) * PW'(bcy);
      p_fb1 <= PW'(dcy) * PW'(bcx);
    end
  end

  always_comb begin
    c1 = CW'(p_bc0) - CW'(p_bc1);
    c2 = CW'(p_bd0) - CW'(p_bd1);
    fa = CW'(p_fa0) - CW'(p_fa1);
    fb = CW'(p_fb0) - CW'(p_fb1);
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      n1      <= c1[CW-1];
      n2      <= c2[CW-1];
      fa_neg  <= fa[CW-1];
      fa_zero <= (fa == '0);
      fb_neg  <= fb[CW-1];
      fb_zero <= (fb == '0);
    end
  end

  // The sign bits of C and D against line AB differ, so line CD meets line AB at one point.
  // That point lies on segment AB exactly when A and B lie on opposite closed sides of CD.
  always_ff @(posedge clk) begin
    if (en4) begin
      hit_q <= (n1 != n2) &&
               (((fa_neg || fa_zero) && !fb_neg) || (!fa_neg && (fb_neg || fb_zero)));
    end
  end

endmodule

### hdl/sit_checker.sv
// Port-level checks on the segment intersection test core, bound to its top level.
module sit_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_hit
);

  localparam int DEPTH = 4;

  logic [2:0] outstanding;

  always_ff @(posedge clk) begin
    if (rst) begin
      outstanding <= '0;
    end else begin
      outstanding <= outstanding + 3'(in_valid && in_ready) - 3'(out_valid && out_ready);
    end
  end

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  a_hold_hit: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_hit))
    else $error("result changed while stalled");

  a_no_invented: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> outstanding != 3'd0)
    else $error("result beat without a pending input beat");

  a_depth: assert property (@(posedge clk) disable iff (rst)
    outstanding <= 3'(DEPTH))
    else $error("more beats in flight than pipeline stages");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind segment_intersection_test_core sit_checker u_sit_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (pts.valid),
  .in_ready  (pts.ready),
  .out_valid (res.valid),
  .out_ready (res.ready),
  .out_hit   (res.hit)
);
